// ----- rtl/core/mva_pkg.sv -----
package mva_pkg;

  localparam int MAX_VOICES_DEF = 8;
  localparam int RESULT_LIMIT   = 8;
  localparam int CNT_W          = $clog2(RESULT_LIMIT + 1);

  localparam int ACT_W   = 2;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int CNUM_W  = 7;
  localparam int CVAL_W  = 14;
  localparam int VIDX_W  = 3;
  localparam int LIDX_W  = 8;
  localparam int LEVEL_W = 16;
  localparam int MAG_W   = 15;

  // 16384/127 = 129 + 1/127: rounding adds one from magnitude 64 on,
  // and magnitude 127 already reaches full scale
  localparam logic [MAG_W-1:0] CTRL_MUL     = MAG_W'(129);
  localparam logic [MAG_W-1:0] CTRL_RND_MAG = MAG_W'(64);
  localparam logic [MAG_W-1:0] CTRL_SAT_MAG = MAG_W'(127);
  localparam logic [MAG_W-1:0] CTRL_SAT     = MAG_W'(16384);

  localparam logic KIND_VOICE = 1'b0;
  localparam logic KIND_LEVEL = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_BEND     = 2'd2,
    ACT_CTRL     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_t;

  // token walking down the voice cells
  typedef struct packed {
    logic             valid;
    logic             rel;
    logic             claimed;
    logic [CNT_W-1:0] cnt;
  } token_t;

  typedef struct packed {
    logic                      kind;
    logic [VIDX_W-1:0]         vidx;
    logic                      gate;
    logic [NOTE_W-1:0]         note;
    logic [VEL_W-1:0]          vel;
    logic [LIDX_W-1:0]         lidx;
    logic signed [LEVEL_W-1:0] level;
  } result_t;

  function automatic logic signed [LEVEL_W-1:0] ctrl_level(
    input logic signed [CVAL_W-1:0] v
  );
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] q;
    mag = v[CVAL_W-1] ? MAG_W'(-{v[CVAL_W-1], v}) : MAG_W'(v);
    if (mag >= CTRL_SAT_MAG) begin
      q = CTRL_SAT;
    end else begin
      q = mag * CTRL_MUL + ((mag >= CTRL_RND_MAG) ? MAG_W'(1) : MAG_W'(0));
    end
    ctrl_level = v[CVAL_W-1] ? -LEVEL_W'(q) : LEVEL_W'(q);
  endfunction

  function automatic logic signed [LEVEL_W-1:0] bend_level(
    input logic signed [CVAL_W-1:0] v
  );
    bend_level = {v[CVAL_W-1], v, 1'b0};
  endfunction

endpackage

// ----- rtl/core/mva_cell.sv -----
module mva_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [mva_pkg::NOTE_W-1:0] note,
  input  mva_pkg::token_t            tok_in,
  output mva_pkg::token_t            tok_out,
  output logic                       hit
);
  import mva_pkg::*;

  logic              busy;
  logic [NOTE_W-1:0] note_q;
  logic              alloc_hit;
  logic              rel_hit;

  assign alloc_hit = tok_in.valid && !tok_in.rel && !tok_in.claimed && !busy;
  assign rel_hit   = tok_in.valid && tok_in.rel && busy && (note_q == note) &&
                     (tok_in.cnt < CNT_W'(RESULT_LIMIT));
  assign hit       = alloc_hit || rel_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      tok_out <= '0;
    end else if (en) begin
      if (alloc_hit) begin
        busy <= 1'b1;
      end else if (rel_hit) begin
        busy <= 1'b0;
      end
      tok_out.valid   <= tok_in.valid;
      tok_out.rel     <= tok_in.rel;
      tok_out.claimed <= tok_in.claimed || alloc_hit;
      tok_out.cnt     <= tok_in.cnt + (rel_hit ? CNT_W'(1) : CNT_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (en && alloc_hit) begin
      note_q <= note;
    end
  end

endmodule

// ----- rtl/core/midi_voice_allocator.sv -----
// channel | handshake            | beat
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_stall  | action, note_number, velocity,
//         |                      | controller_number, control_value
// out     | out_valid / out_stall| result_kind, voice_index, gate, out_note,
//         |                      | out_velocity, level_index, level, last
//
// One event at a time. A note event walks the voice cells, one cell a cycle
// unless the walk is frozen; a pitch bend or controller event skips the walk.
// Output stalls freeze the walk only when a second release is ready while one
// waits. Reset clears all busy flags at once.
module midi_voice_allocator #(
  parameter int MAX_VOICES = mva_pkg::MAX_VOICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mva_pkg::ACT_W-1:0]          action,
  input  logic [mva_pkg::NOTE_W-1:0]         note_number,
  input  logic [mva_pkg::VEL_W-1:0]          velocity,
  input  logic [mva_pkg::CNUM_W-1:0]         controller_number,
  input  logic signed [mva_pkg::CVAL_W-1:0]  control_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               result_kind,
  output logic [mva_pkg::VIDX_W-1:0]         voice_index,
  output logic                               gate,
  output logic [mva_pkg::NOTE_W-1:0]         out_note,
  output logic [mva_pkg::VEL_W-1:0]          out_velocity,
  output logic [mva_pkg::LIDX_W-1:0]         level_index,
  output logic signed [mva_pkg::LEVEL_W-1:0] level,
  output logic                               last
);
  import mva_pkg::*;

  state_t            state;
  state_t            state_next;
  token_t            tok [MAX_VOICES+1];
  logic [MAX_VOICES-1:0] hits;
  logic              emit;
  logic [VIDX_W-1:0] hit_idx;
  logic              adv;
  logic              acc;
  logic              is_ctrl;
  logic              out_free;
  logic              flush_mv;
  logic              emit_mv;
  logic [NOTE_W-1:0] cur_note;
  logic [VEL_W-1:0]  cur_vel;
  logic              cur_rel;
  result_t           hold;
  logic              hold_valid;
  result_t           ctrl_res;
  result_t           voice_res;
  result_t           out_q;
  logic              out_last;

  assign acc      = in_valid && !in_stall;
  assign is_ctrl  = (action_t'(action) == ACT_BEND) || (action_t'(action) == ACT_CTRL);
  assign out_free = !out_valid || !out_stall;
  assign emit     = |hits;
  // hold the chain only when a new beat has nowhere to go
  assign adv      = !emit || !hold_valid || out_free;
  assign flush_mv = (state == S_FLUSH) && hold_valid && out_free;
  assign emit_mv  = (state == S_WALK) && emit && hold_valid && adv;

  genvar g;
  generate
    for (g = 0; g < MAX_VOICES; g++) begin : g_cell
      mva_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .en      (adv),
        .note    (cur_note),
        .tok_in  (tok[g]),
        .tok_out (tok[g+1]),
        .hit     (hits[g])
      );
    end
  endgenerate

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_VOICES; i++) begin
      hit_idx = hit_idx | (hits[i] ? VIDX_W'(i) : VIDX_W'(0));
    end
  end

  always_comb begin
    ctrl_res      = '0;
    ctrl_res.kind = KIND_LEVEL;
    if (action_t'(action) == ACT_BEND) begin
      ctrl_res.level = bend_level(control_value);
    end else begin
      ctrl_res.lidx  = LIDX_W'(controller_number) + LIDX_W'(1);
      ctrl_res.level = ctrl_level(control_value);
    end
  end

  always_comb begin
    voice_res      = '0;
    voice_res.kind = KIND_VOICE;
    voice_res.vidx = hit_idx;
    voice_res.gate = !cur_rel;
    voice_res.note = cur_note;
    voice_res.vel  = cur_vel;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = is_ctrl ? S_FLUSH : S_WALK;
        end
      end
      S_WALK: begin
        if (tok[MAX_VOICES].valid && adv) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!hold_valid || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      S_IDLE:  in_stall = 1'b0;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      tok[0]     <= '0;
    end else begin
      state <= state_next;

      if (acc && !is_ctrl) begin
        tok[0].valid   <= 1'b1;
        tok[0].rel     <= !((action_t'(action) == ACT_NOTE_ON) && (velocity != '0));
        tok[0].claimed <= 1'b0;
        tok[0].cnt     <= '0;
      end else if (adv) begin
        tok[0].valid <= 1'b0;
      end

      if (acc && is_ctrl) begin
        hold_valid <= 1'b1;
      end else if (emit && adv) begin
        hold_valid <= 1'b1;
      end else if (flush_mv) begin
        hold_valid <= 1'b0;
      end

      if (flush_mv || emit_mv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cur_note <= note_number;
      cur_vel  <= velocity;
      cur_rel  <= !((action_t'(action) == ACT_NOTE_ON) && (velocity != '0));
    end
    if (acc && is_ctrl) begin
      hold <= ctrl_res;
    end else if (emit && adv) begin
      hold <= voice_res;
    end
    if (flush_mv || emit_mv) begin
      out_q    <= hold;
      out_last <= flush_mv;
    end
  end

  assign result_kind  = out_q.kind;
  assign voice_index  = out_q.vidx;
  assign gate         = out_q.gate;
  assign out_note     = out_q.note;
  assign out_velocity = out_q.vel;
  assign level_index  = out_q.lidx;
  assign level        = out_q.level;
  assign last         = out_last;

endmodule
